### hw/rtl/pidrl_pkg.sv
`default_nettype none
package pidrl_pkg;

    // data formats
    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int DT_W   = 19;
    localparam int LIM_W  = 31;

    // elapsed time handling, microseconds
    localparam logic [DATA_W-1:0] DT_MAX_US  = 32'd500000;
    localparam logic [DT_W-1:0]   DT_DEF_US  = 19'd1000;

    // shared multiplier and divider sizes
    localparam int MA_W   = 32;
    localparam int MB_W   = 33;
    localparam int PROD_W = MA_W + MB_W;
    localparam int ACC_W  = PROD_W + MA_W;
    localparam int DVD_W  = 84;
    localparam int DVS_W  = 40;
    localparam int CNT_W  = $clog2(DVD_W + 1);

    localparam logic [MB_W-1:0]  US_PER_S_B = 33'd1000000;
    localparam logic [DVD_W-1:0] DERIV_CAP  = 84'd1099511627776;

    // constant division by 15625, radix 2^16 digits, reciprocal per digit
    // two seconds scaled by the fraction bits is 15625 * 2^23, one second is 15625 * 2^6
    localparam int CD_W       = 64;
    localparam int CD_DIG_W   = 16;
    localparam int CD_REM_W   = 14;
    localparam int CD_PART_W  = CD_REM_W + CD_DIG_W;
    localparam int CD_NDIG    = CD_W / CD_DIG_W;
    localparam int CD_CNT_W   = 2;
    localparam int CD_MAGIC_W = 33;
    localparam int CD_SHIFT   = 46;
    localparam int INTEG_SH   = 23;
    localparam int RAMP_SH    = 6;
    localparam logic [CD_REM_W-1:0]   CD_DIVISOR = 14'd15625;
    localparam logic [CD_MAGIC_W-1:0] CD_MAGIC   = 33'd4503599628;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_RATE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 3'd4;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_DIV_GO,
        OP_SET_P,
        OP_SET_I,
        OP_SET_D,
        OP_SET_R,
        OP_OUT
    } t_op;

    // operand selection for multiply and divide
    typedef enum logic [2:0] {
        SRC_P,
        SRC_I1,
        SRC_I2,
        SRC_D1,
        SRC_D2,
        SRC_RR,
        SRC_CM
    } t_src;

    typedef struct packed {
        t_op  op;
        t_src src;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic ramp_on;
    } t_stat;

endpackage
`default_nettype wire

### hw/rtl/pidrl_if.sv
`default_nettype none
interface pidrl_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] error_in;
    logic [31:0]        time_now_us;
    modport source(output valid, output error_in, output time_now_us, input ready);
    modport sink(input valid, input error_in, input time_now_us, output ready);
endinterface

interface pidrl_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive_out;
    modport source(output valid, output drive_out, input ready);
    modport sink(input valid, input drive_out, output ready);
endinterface
`default_nettype wire

### hw/rtl/pidrl_div.sv
`default_nettype none
module pidrl_div
    import pidrl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_go,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_busy,
    output logic [DVD_W-1:0]      o_quotient
);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W:0]   trial;
    logic             fits;
    logic [DVS_W:0]   diff;

    // one restoring step: shift in next dividend bit, subtract if it fits
    assign trial = {r_rem, r_quo[DVD_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go && !r_busy) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DVD_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_go && !r_busy) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

    a_go_starts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && !r_busy) |=> (r_busy && r_cnt == '0))
        else $error("divider did not start");

endmodule

// division by the constant 15625, one 16-bit digit at a time: reciprocal multiply, then remainder update
module pidrl_cdiv
    import pidrl_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_go,
    input  wire logic [CD_W-1:0] i_dividend,
    output logic                 o_busy,
    output logic [CD_W-1:0]      o_quotient
);

    logic                              r_busy;
    logic                              r_phase;
    logic [CD_CNT_W-1:0]               r_cnt;
    logic [CD_W-1:0]                   r_num;
    logic [CD_W-1:0]                   r_quo;
    logic [CD_REM_W-1:0]               r_rem;
    logic [CD_DIG_W-1:0]               r_dig;
    logic [CD_PART_W-1:0]              part;
    logic [CD_PART_W+CD_MAGIC_W-1:0]   rprod;
    logic [CD_PART_W-1:0]              back;
    logic [CD_PART_W-1:0]              rem;

    // partial remainder with the next digit, digit by reciprocal multiply
    assign part  = {r_rem, r_num[CD_W-1 -: CD_DIG_W]};
    assign rprod = (CD_PART_W+CD_MAGIC_W)'(part) * (CD_PART_W+CD_MAGIC_W)'(CD_MAGIC);
    // remainder in the following cycle
    assign back  = CD_PART_W'(r_dig) * CD_PART_W'(CD_DIVISOR);
    assign rem   = part - back;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else if (i_go && !r_busy) begin
            r_busy  <= 1'b1;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else if (r_busy) begin
            r_phase <= ~r_phase;
            if (r_phase) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CD_CNT_W'(CD_NDIG - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // digit, remainder and quotient registers
    always_ff @(posedge i_clk) begin
        if (i_go && !r_busy) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_dig <= rprod[CD_SHIFT +: CD_DIG_W];
            end else begin
                r_rem <= rem[CD_REM_W-1:0];
                r_quo <= {r_quo[CD_W-CD_DIG_W-1:0], r_dig};
                r_num <= {r_num[CD_W-CD_DIG_W-1:0], {CD_DIG_W{1'b0}}};
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

    a_rem_below_divisor : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < CD_DIVISOR))
        else $error("constant divider remainder out of range");

endmodule
`default_nettype wire

### hw/rtl/pidrl_dp.sv
`default_nettype none
module pidrl_dp
    import pidrl_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [DATA_W-1:0]        i_cfg_data,
    input  wire t_cmd                     i_cmd,
    output t_stat                         o_stat,
    input  wire logic signed [DATA_W-1:0] i_error_in,
    input  wire logic [DATA_W-1:0]        i_time_now_us,
    output logic signed [DATA_W-1:0]      o_drive_out
);

    // configuration
    logic signed [DATA_W-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic [LIM_W-1:0]         r_ramp, r_lim;
    // controller state
    logic signed [DATA_W-1:0] r_last_e, r_last_drive, r_isum;
    logic [DATA_W-1:0]        r_last_time;
    // working registers
    logic signed [DATA_W-1:0] r_e, r_integ, r_drive, r_out;
    logic [DATA_W-1:0]        r_now;
    logic signed [47:0]       r_p;
    logic [ACC_W-1:0]         r_acc;
    logic [63:0]              r_a;
    logic [MB_W-1:0]          r_b;
    logic [50:0]              r_rhs;

    logic [DATA_W-1:0]  dt_raw;
    logic [DT_W-1:0]    dt;
    logic [DATA_W:0]    sum, dif, sum_mag, dif_mag;
    logic [DATA_W-1:0]  e_mag, kp_mag, ki_mag, kd_mag;
    logic [DATA_W:0]    chg;
    logic [DATA_W-1:0]  chg_mag;
    logic [63:0]        a_sel;
    logic [MB_W-1:0]    b_sel;
    logic [MA_W-1:0]    mul_a;
    logic [MB_W-1:0]    mul_b;
    logic [PROD_W-1:0]  prod;
    logic               div_go, div_busy;
    logic [DVD_W-1:0]   quo;
    logic [DVS_W-1:0]   dvs_sel;
    logic               cdiv_go, cdiv_busy;
    logic [CD_W-1:0]    cdiv_dvd;
    logic [CD_W-1:0]    cq;
    logic signed [47:0] p_val, integ_raw;
    logic [45:0]        di_mag;
    logic [40:0]        dd_mag;
    logic signed [49:0] d_val, total;
    logic signed [DATA_W-1:0] integ_clamped, drive_clamped, ramped;
    logic [30:0]        step;
    logic signed [33:0] ramp_sum;
    logic               over;

    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic signed [DATA_W-1:0] lim_clamp(
        input logic signed [49:0] v, input logic [LIM_W-1:0] lim);
        logic signed [49:0] hi;
        hi = $signed({19'b0, lim});
        if (v > hi)       return DATA_W'(hi);
        else if (v < -hi) return DATA_W'(-hi);
        else              return DATA_W'(v);
    endfunction

    // elapsed time, with out-of-range values replaced
    assign dt_raw = r_now - r_last_time;
    assign dt     = (dt_raw == '0 || dt_raw > DT_MAX_US) ? DT_DEF_US : dt_raw[DT_W-1:0];

    // operand magnitudes
    assign sum     = {r_e[DATA_W-1], r_e} + {r_last_e[DATA_W-1], r_last_e};
    assign dif     = {r_e[DATA_W-1], r_e} - {r_last_e[DATA_W-1], r_last_e};
    assign sum_mag = sum[DATA_W] ? (~sum + 1'b1) : sum;
    assign dif_mag = dif[DATA_W] ? (~dif + 1'b1) : dif;
    assign e_mag   = mag32(r_e);
    assign kp_mag  = mag32(r_gain_p);
    assign ki_mag  = mag32(r_gain_i);
    assign kd_mag  = mag32(r_gain_d);
    assign chg     = {r_drive[DATA_W-1], r_drive} - {r_last_drive[DATA_W-1], r_last_drive};
    assign chg_mag = chg[DATA_W] ? DATA_W'(~chg + 1'b1) : chg[DATA_W-1:0];

    // multiplier operand selection
    always_comb begin
        a_sel = '0;
        b_sel = '0;
        case (i_cmd.src)
            SRC_P:  begin a_sel = 64'(kp_mag);        b_sel = MB_W'(e_mag); end
            SRC_I1: begin a_sel = 64'(ki_mag);        b_sel = sum_mag;      end
            SRC_I2: begin a_sel = r_acc[63:0];        b_sel = MB_W'(dt);    end
            SRC_D1: begin a_sel = 64'(kd_mag);        b_sel = dif_mag;      end
            SRC_D2: begin a_sel = r_acc[63:0];        b_sel = US_PER_S_B;   end
            SRC_RR: begin a_sel = 64'(r_ramp);        b_sel = MB_W'(dt);    end
            SRC_CM: begin a_sel = 64'(chg_mag);       b_sel = US_PER_S_B;   end
            default: begin a_sel = '0;                b_sel = '0;           end
        endcase
    end

    // shared multiplier, low half then high half of a wide operand
    assign mul_a = (i_cmd.op == OP_MUL_HI) ? r_a[63:32] : a_sel[MA_W-1:0];
    assign mul_b = (i_cmd.op == OP_MUL_HI) ? r_b : b_sel;
    assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

    // derivative divides by the elapsed time, the rest by a constant
    assign dvs_sel = DVS_W'({dt, {FRAC_W{1'b0}}});
    assign div_go  = (i_cmd.op == OP_DIV_GO) && (i_cmd.src == SRC_D2);
    assign cdiv_go = (i_cmd.op == OP_DIV_GO) && (i_cmd.src != SRC_D2);

    pidrl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (div_go),
        .i_dividend (r_acc[DVD_W-1:0]),
        .i_divisor  (dvs_sel),
        .o_busy     (div_busy),
        .o_quotient (quo)
    );

    // power-of-two part of the constant divisor taken off by a shift
    assign cdiv_dvd = (i_cmd.src == SRC_RR) ? r_acc[RAMP_SH +: CD_W] : r_acc[INTEG_SH +: CD_W];

    pidrl_cdiv u_cdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (cdiv_go),
        .i_dividend (cdiv_dvd),
        .o_busy     (cdiv_busy),
        .o_quotient (cq)
    );

    // proportional term
    assign p_val = (r_gain_p[DATA_W-1] ^ r_e[DATA_W-1]) ?
                   -$signed({1'b0, r_acc[62:16]}) : $signed({1'b0, r_acc[62:16]});

    // trapezoidal integral
    assign di_mag    = cq[45:0];
    assign integ_raw = 48'(r_isum) + ((r_gain_i[DATA_W-1] ^ sum[DATA_W]) ?
                       -$signed({2'b0, di_mag}) : $signed({2'b0, di_mag}));
    assign integ_clamped = lim_clamp(50'(integ_raw), r_lim);

    // derivative, capped, and the clamped sum
    assign dd_mag  = (quo > DERIV_CAP) ? DERIV_CAP[40:0] : quo[40:0];
    assign d_val   = (r_gain_d[DATA_W-1] ^ dif[DATA_W]) ?
                     -$signed({9'b0, dd_mag}) : $signed({9'b0, dd_mag});
    assign total   = 50'(r_p) + 50'(r_integ) + d_val;
    assign drive_clamped = lim_clamp(total, r_lim);

    // ramp limit: compare change*1e6 against ramp*dt
    assign over     = r_acc[52:0] > {2'b0, r_rhs};
    assign step     = cq[30:0];
    assign ramp_sum = chg[DATA_W] ? (34'(r_last_drive) - $signed({3'b0, step}))
                                  : (34'(r_last_drive) + $signed({3'b0, step}));
    always_comb begin
        if (ramp_sum > 34'sh7FFFFFFF)       ramped = 32'sh7FFFFFFF;
        else if (ramp_sum < -34'sh80000000) ramped = -32'sh80000000;
        else                                ramped = ramp_sum[DATA_W-1:0];
    end

    // configuration and persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p     <= '0;
            r_gain_i     <= '0;
            r_gain_d     <= '0;
            r_ramp       <= '0;
            r_lim        <= '0;
            r_last_e     <= '0;
            r_last_drive <= '0;
            r_isum       <= '0;
            r_last_time  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_GAIN_P:       r_gain_p <= i_cfg_data;
                    REG_GAIN_I:       r_gain_i <= i_cfg_data;
                    REG_GAIN_D:       r_gain_d <= i_cfg_data;
                    REG_RAMP_RATE:    r_ramp   <= i_cfg_data[LIM_W-1:0];
                    REG_OUTPUT_LIMIT: r_lim    <= i_cfg_data[LIM_W-1:0];
                    default:          ;
                endcase
            end
            if (i_cmd.op == OP_OUT) begin
                r_last_e     <= r_e;
                r_last_drive <= r_drive;
                r_isum       <= r_integ;
                r_last_time  <= r_now;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_e   <= i_error_in;
                r_now <= i_time_now_us;
            end
            OP_MUL_LO: begin
                r_a   <= a_sel;
                r_b   <= b_sel;
                r_acc <= ACC_W'(prod);
            end
            OP_MUL_HI: r_acc <= r_acc + {prod, {MA_W{1'b0}}};
            OP_DIV_GO: r_rhs <= r_acc[50:0];
            OP_SET_P:  r_p <= p_val;
            OP_SET_I:  r_integ <= integ_clamped;
            OP_SET_D:  r_drive <= drive_clamped;
            OP_SET_R:  if (over && chg != '0) r_drive <= ramped;
            OP_OUT:    r_out <= r_drive;
            default:   ;
        endcase
    end

    assign o_stat.div_busy = div_busy | cdiv_busy;
    assign o_stat.ramp_on  = (r_ramp != '0);
    assign o_drive_out     = r_out;

    a_drive_in_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_SET_D) |=>
        (r_drive <= $signed({1'b0, $past(r_lim)}) && r_drive >= -$signed({1'b0, $past(r_lim)})))
        else $error("clamped drive beyond limit");

    a_integ_in_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_SET_I) |=>
        (r_integ <= $signed({1'b0, $past(r_lim)}) && r_integ >= -$signed({1'b0, $past(r_lim)})))
        else $error("integral beyond limit");

endmodule
`default_nettype wire

### hw/rtl/pidrl_ctrl.sv
`default_nettype none
module pidrl_ctrl
    import pidrl_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_P_LO, ST_P_SET, ST_I1, ST_I2_LO, ST_I2_HI, ST_I_DIV, ST_I_WAIT,
        ST_I_SET, ST_D1, ST_D2_LO, ST_D2_HI, ST_D_DIV, ST_D_WAIT, ST_D_SET,
        ST_R_MUL, ST_R_DIV, ST_R_WAIT, ST_C_MUL, ST_R_SET, ST_HOLD, ST_OUT
    } t_state;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic   r_in_ready, r_out_valid;

    function automatic t_cmd cmd_of(input t_state s);
        t_cmd c;
        c.op  = OP_NOP;
        c.src = SRC_P;
        case (s)
            ST_IDLE:  c.op = OP_LOAD;
            ST_P_LO:  begin c.op = OP_MUL_LO; c.src = SRC_P;  end
            ST_P_SET: c.op = OP_SET_P;
            ST_I1:    begin c.op = OP_MUL_LO; c.src = SRC_I1; end
            ST_I2_LO: begin c.op = OP_MUL_LO; c.src = SRC_I2; end
            ST_I2_HI: c.op = OP_MUL_HI;
            ST_I_DIV: begin c.op = OP_DIV_GO; c.src = SRC_I2; end
            ST_I_SET: c.op = OP_SET_I;
            ST_D1:    begin c.op = OP_MUL_LO; c.src = SRC_D1; end
            ST_D2_LO: begin c.op = OP_MUL_LO; c.src = SRC_D2; end
            ST_D2_HI: c.op = OP_MUL_HI;
            ST_D_DIV: begin c.op = OP_DIV_GO; c.src = SRC_D2; end
            ST_D_SET: c.op = OP_SET_D;
            ST_R_MUL: begin c.op = OP_MUL_LO; c.src = SRC_RR; end
            ST_R_DIV: begin c.op = OP_DIV_GO; c.src = SRC_RR; end
            ST_C_MUL: begin c.op = OP_MUL_LO; c.src = SRC_CM; end
            ST_R_SET: c.op = OP_SET_R;
            ST_OUT:   c.op = OP_OUT;
            default:  c.op = OP_NOP;
        endcase
        return c;
    endfunction

    // sequencing of the datapath steps
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_P_LO;
            ST_P_LO:   n_state = ST_P_SET;
            ST_P_SET:  n_state = ST_I1;
            ST_I1:     n_state = ST_I2_LO;
            ST_I2_LO:  n_state = ST_I2_HI;
            ST_I2_HI:  n_state = ST_I_DIV;
            ST_I_DIV:  n_state = ST_I_WAIT;
            ST_I_WAIT: if (!i_stat.div_busy) n_state = ST_I_SET;
            ST_I_SET:  n_state = ST_D1;
            ST_D1:     n_state = ST_D2_LO;
            ST_D2_LO:  n_state = ST_D2_HI;
            ST_D2_HI:  n_state = ST_D_DIV;
            ST_D_DIV:  n_state = ST_D_WAIT;
            ST_D_WAIT: if (!i_stat.div_busy) n_state = ST_D_SET;
            ST_D_SET:  n_state = i_stat.ramp_on ? ST_R_MUL : ST_HOLD;
            ST_R_MUL:  n_state = ST_R_DIV;
            ST_R_DIV:  n_state = ST_R_WAIT;
            ST_R_WAIT: if (!i_stat.div_busy) n_state = ST_C_MUL;
            ST_C_MUL:  n_state = ST_R_SET;
            ST_R_SET:  n_state = ST_HOLD;
            ST_HOLD:   if (!r_out_valid || i_out_ready) n_state = ST_OUT;
            ST_OUT:    n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cmd       <= cmd_of(ST_IDLE);
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cmd      <= cmd_of(n_state);
            r_in_ready <= (n_state == ST_IDLE);
            if (r_state == ST_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = r_cmd;

endmodule
`default_nettype wire

### hw/rtl/pid_controller_with_ramp_limit.sv
// each input word runs the whole step sequence before the next word is taken, and ramp
// limiting on adds the ramp steps; the 84-step derivative division sets most of the
// time spent on each word
// a new input word is taken while the previous result waits in the output register
// synchronous active-low reset returns the sequencer to idle and clears gains, limits,
// stored error, drive, integral and timestamp to zero
`default_nettype none
module pid_controller_with_ramp_limit
    import pidrl_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [DATA_W-1:0]    i_cfg_data,
    pidrl_in_if.sink                  i_in_ch,
    pidrl_out_if.source               o_out_ch
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready, out_valid;

    // sequencer
    pidrl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out_ch.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // arithmetic and state
    pidrl_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_error_in    (i_in_ch.error_in),
        .i_time_now_us (i_in_ch.time_now_us),
        .o_drive_out   (o_out_ch.drive_out)
    );

    assign i_in_ch.ready  = in_ready;
    assign o_out_ch.valid = out_valid;

endmodule
`default_nettype wire
